// ===== src/jsu_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the json string unescape block
// no dependencies
package jsu_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int MAX_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > MAX_WIDTH) ? COUNT_WIDTH : MAX_WIDTH;

  localparam logic [MAX_WIDTH-1:0] MAX_BYTES_RESET = MAX_WIDTH'(16000);
  localparam logic [MAX_WIDTH-1:0] LIMIT_MARGIN    = MAX_WIDTH'(4);

  // byte codes
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_APOS      = 8'h27;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  // utf-8 lead and continuation classes
  localparam logic [7:0] UTF_LEAD2    = 8'hC0;
  localparam logic [7:0] UTF_LEAD3    = 8'hE0;
  localparam logic [7:0] UTF_LEAD4    = 8'hF0;
  localparam logic [7:0] UTF_CONT_TAG = 8'h80;
  localparam logic [7:0] UTF_TAG_MASK = 8'hC0;
  localparam logic [7:0] UTF_PAY_MASK = 8'h3F;

  localparam logic [31:0] HEX_DIGIT_BIAS = 32'h30;
  localparam logic [31:0] HEX_ALPHA_BIAS = 32'h57;

  // wide code points folded to ascii
  localparam logic [31:0] CP_LSQUOTE = 32'h2018;
  localparam logic [31:0] CP_RSQUOTE = 32'h2019;
  localparam logic [31:0] CP_LDQUOTE = 32'h201C;
  localparam logic [31:0] CP_RDQUOTE = 32'h201D;
  localparam logic [31:0] CP_ENDASH  = 32'h2013;
  localparam logic [31:0] CP_EMDASH  = 32'h2014;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_ESCAPE = 5'b00010,
    MODE_HEX    = 5'b00100,
    MODE_UTF8   = 5'b01000,
    MODE_DONE   = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       run_last;
  } result_t;

  // up to two results produced by one input byte
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [7:0] map_code(input logic [31:0] c);
    logic [7:0] m;
    if (c[31:8] == 24'd0) begin
      m = c[7:0];
    end else if (c == CP_LSQUOTE || c == CP_RSQUOTE) begin
      m = CH_APOS;
    end else if (c == CP_LDQUOTE || c == CP_RDQUOTE) begin
      m = CH_QUOTE;
    end else if (c == CP_ENDASH || c == CP_EMDASH) begin
      m = CH_DASH;
    end else begin
      m = CH_QUESTION;
    end
    return m;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH-1:0] r;
    if (c == {COUNT_WIDTH{1'b1}}) begin
      r = c;
    end else begin
      r = c + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/jsu_if.sv =====
`timescale 1ns / 1ps
// channel interfaces for the json string unescape block: input, result, config
// depends on jsu_pkg
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_start;
  modport source (output valid, output in_byte, output string_start, input ready);
  modport sink   (input valid, input in_byte, input string_start, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic       run_last;
  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  input run_last, output ready);
endinterface

interface jsu_cfg_if
  import jsu_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [MAX_WIDTH-1:0] max_bytes;
  modport source (output valid, output max_bytes, input ready);
  modport sink   (input valid, input max_bytes, output ready);
endinterface

// ===== src/jsu_decode.sv =====
`timescale 1ns / 1ps
// decoder state and single-pass step logic for one registered input byte
// depends on jsu_pkg
module jsu_decode
  import jsu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           in_byte,
  input  logic                 string_start,
  input  logic [MAX_WIDTH-1:0] max_bytes,
  output push_t                push
);

  mode_t                  decode_mode;
  logic [31:0]            code_value;
  logic [2:0]             digits_left;
  logic [COUNT_WIDTH-1:0] written_count;

  mode_t                  decode_mode_next;
  logic [31:0]            code_value_next;
  logic [2:0]             digits_left_next;
  logic [COUNT_WIDTH-1:0] written_count_next;

  logic [MAX_WIDTH-1:0]   lim;
  logic [31:0]            hex_digit;
  logic [1:0]             nres;
  result_t                r0;
  result_t                r1;
  result_t                fr;
  logic                   do_fresh;

  assign lim = (max_bytes >= LIMIT_MARGIN) ? (max_bytes - LIMIT_MARGIN) : '0;

  function automatic logic hit(input logic [COUNT_WIDTH-1:0] c,
                               input logic [MAX_WIDTH-1:0] l);
    return CMP_WIDTH'(c) >= CMP_WIDTH'(l);
  endfunction

  // digit value wraps like unsigned arithmetic for non-hex bytes
  assign hex_digit = (in_byte <= CH_NINE) ? ({24'd0, in_byte} - HEX_DIGIT_BIAS)
                                          : ({24'd0, in_byte | CASE_BIT} - HEX_ALPHA_BIAS);

  always_comb begin
    decode_mode_next   = string_start ? MODE_NORMAL : decode_mode;
    code_value_next    = string_start ? '0 : code_value;
    digits_left_next   = string_start ? '0 : digits_left;
    written_count_next = string_start ? '0 : written_count;
    nres     = 2'd0;
    r0       = '0;
    r1       = '0;
    fr       = '0;
    do_fresh = 1'b0;

    unique case (decode_mode_next)
      MODE_DONE: begin
      end
      MODE_ESCAPE: begin
        if (in_byte == CH_NUL) begin
          r0.string_done   = 1'b1;
          nres             = 2'd1;
          decode_mode_next = MODE_DONE;
        end else if (in_byte == CH_LOWER_N) begin
          r0.out_byte        = CH_CR;
          r0.byte_valid      = 1'b1;
          r1.out_byte        = CH_LF;
          r1.byte_valid      = 1'b1;
          nres               = 2'd2;
          written_count_next = count_inc(count_inc(written_count_next));
          decode_mode_next   = MODE_NORMAL;
          if (hit(written_count_next, lim)) begin
            r1.string_done   = 1'b1;
            decode_mode_next = MODE_DONE;
          end
        end else if (in_byte == CH_LOWER_U) begin
          code_value_next  = '0;
          digits_left_next = 3'd4;
          decode_mode_next = MODE_HEX;
        end else if (in_byte == CH_LOWER_R) begin
          decode_mode_next = MODE_NORMAL;
        end else begin
          r0.out_byte        = (in_byte == CH_LOWER_T) ? CH_SPACE : in_byte;
          r0.byte_valid      = 1'b1;
          nres               = 2'd1;
          written_count_next = count_inc(written_count_next);
          decode_mode_next   = MODE_NORMAL;
          if (hit(written_count_next, lim)) begin
            r0.string_done   = 1'b1;
            decode_mode_next = MODE_DONE;
          end
        end
      end
      MODE_HEX: begin
        if (in_byte == CH_NUL) begin
          r0.out_byte        = map_code(code_value_next);
          r0.byte_valid      = 1'b1;
          r0.string_done     = 1'b1;
          nres               = 2'd1;
          written_count_next = count_inc(written_count_next);
          decode_mode_next   = MODE_DONE;
        end else begin
          code_value_next = {code_value_next[27:0], 4'd0} + hex_digit;
          if (digits_left_next != 3'd0) begin
            digits_left_next = digits_left_next - 3'd1;
          end
          if (digits_left_next == 3'd0) begin
            r0.out_byte        = map_code(code_value_next);
            r0.byte_valid      = 1'b1;
            nres               = 2'd1;
            written_count_next = count_inc(written_count_next);
            decode_mode_next   = MODE_NORMAL;
            if (hit(written_count_next, lim)) begin
              r0.string_done   = 1'b1;
              decode_mode_next = MODE_DONE;
            end
          end
        end
      end
      MODE_UTF8: begin
        if ((in_byte & UTF_TAG_MASK) == UTF_CONT_TAG) begin
          code_value_next = {code_value_next[25:0], in_byte[5:0]};
          if (digits_left_next != 3'd0) begin
            digits_left_next = digits_left_next - 3'd1;
          end
          if (digits_left_next == 3'd0) begin
            r0.out_byte        = map_code(code_value_next);
            r0.byte_valid      = 1'b1;
            nres               = 2'd1;
            written_count_next = count_inc(written_count_next);
            decode_mode_next   = MODE_NORMAL;
            if (hit(written_count_next, lim)) begin
              r0.string_done   = 1'b1;
              decode_mode_next = MODE_DONE;
            end
          end
        end else begin
          // short sequence: flush the partial code, then take the byte afresh
          digits_left_next   = '0;
          r0.out_byte        = map_code(code_value_next);
          r0.byte_valid      = 1'b1;
          nres               = 2'd1;
          written_count_next = count_inc(written_count_next);
          decode_mode_next   = MODE_NORMAL;
          if (hit(written_count_next, lim)) begin
            r0.string_done   = 1'b1;
            decode_mode_next = MODE_DONE;
          end else begin
            do_fresh = 1'b1;
          end
        end
      end
      default: begin
        decode_mode_next = MODE_NORMAL;
        do_fresh         = 1'b1;
      end
    endcase

    if (do_fresh) begin
      if (hit(written_count_next, lim) || in_byte == CH_NUL || in_byte == CH_QUOTE) begin
        decode_mode_next = MODE_DONE;
        r0.string_done   = 1'b1;
        if (nres == 2'd0) begin
          nres = 2'd1;
        end
      end else if (in_byte == CH_BACKSLASH) begin
        decode_mode_next = MODE_ESCAPE;
      end else if (in_byte >= UTF_LEAD2) begin
        if (in_byte >= UTF_LEAD4) begin
          digits_left_next = 3'd3;
          code_value_next  = {29'd0, in_byte[2:0]};
        end else if (in_byte >= UTF_LEAD3) begin
          digits_left_next = 3'd2;
          code_value_next  = {28'd0, in_byte[3:0]};
        end else begin
          digits_left_next = 3'd1;
          code_value_next  = {27'd0, in_byte[4:0]};
        end
        decode_mode_next = MODE_UTF8;
      end else begin
        fr.out_byte        = in_byte;
        fr.byte_valid      = 1'b1;
        written_count_next = count_inc(written_count_next);
        decode_mode_next   = MODE_NORMAL;
        if (hit(written_count_next, lim)) begin
          fr.string_done   = 1'b1;
          decode_mode_next = MODE_DONE;
        end
        if (nres == 2'd0) begin
          r0 = fr;
        end else begin
          r1 = fr;
        end
        nres = nres + 2'd1;
      end
    end

    if (nres == 2'd2) begin
      r1.run_last = 1'b1;
    end else if (nres == 2'd1) begin
      r0.run_last = 1'b1;
    end
  end

  assign push.count  = step ? nres : 2'd0;
  assign push.first  = r0;
  assign push.second = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode   <= MODE_NORMAL;
      code_value    <= '0;
      digits_left   <= '0;
      written_count <= '0;
    end else if (step) begin
      decode_mode   <= decode_mode_next;
      code_value    <= code_value_next;
      digits_left   <= digits_left_next;
      written_count <= written_count_next;
    end
  end

endmodule

// ===== src/jsu_result_queue.sv =====
`timescale 1ns / 1ps
// four-entry result queue taking up to two results a cycle, one out a cycle
// depends on jsu_pkg
module jsu_result_queue
  import jsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int DEPTH = 4;

  result_t    entries [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid & out_ready;
  // two free slots guaranteed whatever the sink does this cycle
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push.count} - {2'b00, pop};
    end
  end

endmodule

// ===== src/json_string_unescape_utf8_top.sv =====
`timescale 1ns / 1ps
// top level of the json string unescape block: input register, decoder, result queue
// depends on jsu_pkg, jsu_if, jsu_decode, jsu_result_queue
//
// Decodes a JSON string body, one byte per transfer, into single-byte text. Each byte
// is held in an input register and decoded into zero, one or two results, which go into
// a four-entry result queue; a result is offered on the result port once it is in the
// queue. One byte is taken every cycle while the sink keeps up; the limit is the result
// port, which hands out one result per cycle, so a byte that yields two results
// (backslash-n, or a cut-short UTF-8 sequence followed by a character) needs two result
// transfers, and input stalls once the queue holds more than two.
// max_bytes is written through the configuration channel, which is always ready.
module json_string_unescape_utf8_top
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch,
  jsu_cfg_if.sink    cfg_ch
);

  logic [MAX_WIDTH-1:0] max_bytes;
  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 string_start;
  logic                 room;
  logic                 step;
  push_t                push;
  result_t              out_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (cfg_ch.valid) begin
      max_bytes <= cfg_ch.max_bytes;
    end
  end

  // the held byte is decoded once the queue can take two results
  assign step        = in_valid & room;
  assign in_ch.ready = ~in_valid | room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte      <= in_ch.in_byte;
      string_start <= in_ch.string_start;
    end
  end

  jsu_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .in_byte      (in_byte),
    .string_start (string_start),
    .max_bytes    (max_bytes),
    .push         (push)
  );

  jsu_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.out_byte    = out_data.out_byte;
  assign out_ch.byte_valid  = out_data.byte_valid;
  assign out_ch.string_done = out_data.string_done;
  assign out_ch.run_last    = out_data.run_last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for json_string_unescape_utf8_top: random string bodies, max_bytes settings
// depends on jsu_pkg, jsu_if and the rtl under src
module tb;
  import jsu_pkg::*;

  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_BYTES     = 72;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } body_item_t;

  logic clk;
  logic rst;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();
  jsu_cfg_if cfg_ch ();

  json_string_unescape_utf8_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  body_item_t body_q[$];
  result_t    decoded_q[$];

  bit idle_en;
  bit start_due;
  int gap_left;
  int stall_left;
  int n_fed;
  int n_in;
  int n_checked;
  int n_strings;
  int n_cfg;
  int errors;

  // decoder state mirrored on the bench side
  logic [MAX_WIDTH-1:0]   pr_max = MAX_BYTES_RESET;
  mode_t                  pr_mode = MODE_NORMAL;
  logic [31:0]            pr_code = '0;
  logic [2:0]             pr_left = '0;
  logic [COUNT_WIDTH-1:0] pr_count = '0;
  result_t                step_res[2];
  int                     step_n;

  function automatic logic [7:0] fold_cp(input logic [31:0] cp);
    logic [7:0] r;
    if (cp < 32'h100) begin
      r = cp[7:0];
    end else begin
      case (cp)
        CP_LSQUOTE, CP_RSQUOTE: r = CH_APOS;
        CP_LDQUOTE, CP_RDQUOTE: r = CH_QUOTE;
        CP_ENDASH, CP_EMDASH:   r = CH_DASH;
        default:                r = CH_QUESTION;
      endcase
    end
    return r;
  endfunction

  function automatic bit at_limit();
    logic [MAX_WIDTH-1:0] lim;
    lim = (pr_max >= LIMIT_MARGIN) ? pr_max - LIMIT_MARGIN : '0;
    return CMP_WIDTH'(pr_count) >= CMP_WIDTH'(lim);
  endfunction

  function automatic void put_char(input logic [31:0] cp);
    step_res[step_n] = '{out_byte: fold_cp(cp), byte_valid: 1'b1, string_done: 1'b0,
                         run_last: 1'b0};
    step_n++;
    if (pr_count != '1) pr_count = pr_count + 1'b1;
  endfunction

  // a string that ends without a character still gives one result
  function automatic void finish_string();
    pr_mode = MODE_DONE;
    if (step_n == 0) begin
      step_res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, string_done: 1'b1, run_last: 1'b0};
      step_n = 1;
    end else begin
      step_res[step_n-1].string_done = 1'b1;
    end
  endfunction

  function automatic bit close_char();
    pr_mode = MODE_NORMAL;
    if (at_limit()) begin
      finish_string();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void start_byte(input logic [7:0] b);
    logic [2:0] n;
    if (at_limit() || b == CH_NUL || b == CH_QUOTE) begin
      finish_string();
    end else if (b == CH_BACKSLASH) begin
      pr_mode = MODE_ESCAPE;
    end else if (b >= UTF_LEAD2) begin
      n = (b >= UTF_LEAD4) ? 3'd3 : ((b >= UTF_LEAD3) ? 3'd2 : 3'd1);
      pr_code = 32'(b & (UTF_PAY_MASK >> n));
      pr_left = n;
      pr_mode = MODE_UTF8;
    end else begin
      put_char(32'(b));
      void'(close_char());
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic first);
    logic [31:0] dig;
    int k;
    step_n = 0;
    if (first) begin
      pr_mode = MODE_NORMAL;
      pr_code = '0;
      pr_left = '0;
      pr_count = '0;
    end
    case (pr_mode)
      MODE_DONE: ;
      MODE_ESCAPE: begin
        if (b == CH_NUL) begin
          finish_string();
        end else if (b == CH_LOWER_N) begin
          put_char(32'(CH_CR));
          put_char(32'(CH_LF));
          void'(close_char());
        end else if (b == CH_LOWER_T) begin
          put_char(32'(CH_SPACE));
          void'(close_char());
        end else if (b == CH_LOWER_U) begin
          pr_code = '0;
          pr_left = 3'd4;
          pr_mode = MODE_HEX;
        end else if (b == CH_LOWER_R) begin
          pr_mode = MODE_NORMAL;
        end else begin
          put_char(32'(b));
          void'(close_char());
        end
      end
      MODE_HEX: begin
        if (b == CH_NUL) begin
          put_char(pr_code);
          finish_string();
        end else begin
          // any non-nul byte counts as a digit, wrapping as unsigned
          dig = (b <= CH_NINE) ? 32'(b) - HEX_DIGIT_BIAS : 32'(b | CASE_BIT) - HEX_ALPHA_BIAS;
          pr_code = (pr_code << 4) + dig;
          if (pr_left != 0) pr_left = pr_left - 3'd1;
          if (pr_left == 0) begin
            put_char(pr_code);
            void'(close_char());
          end
        end
      end
      MODE_UTF8: begin
        if ((b & UTF_TAG_MASK) == UTF_CONT_TAG) begin
          pr_code = (pr_code << 6) | 32'(b & UTF_PAY_MASK);
          if (pr_left != 0) pr_left = pr_left - 3'd1;
          if (pr_left == 0) begin
            put_char(pr_code);
            void'(close_char());
          end
        end else begin
          // cut-short sequence: flush the partial code, then take the byte afresh
          pr_left = '0;
          put_char(pr_code);
          if (!close_char()) start_byte(b);
        end
      end
      default: begin
        pr_mode = MODE_NORMAL;
        start_byte(b);
      end
    endcase
    if (step_n > 0) step_res[step_n-1].run_last = 1'b1;
    for (k = 0; k < step_n; k++) decoded_q.push_back(step_res[k]);
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
      errors++;
    end
  endfunction

  // stimulus helpers
  function automatic void feed(input logic [7:0] b);
    body_q.push_back('{data: b, first: start_due});
    start_due = 1'b0;
    n_fed++;
  endfunction

  function automatic void feed_text(input string txt);
    int i;
    for (i = 0; i < txt.len(); i++) feed(txt[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    // either letter case
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  function automatic logic [31:0] wide_cp(input int sel);
    logic [31:0] cp;
    case (sel)
      0:       cp = CP_LSQUOTE;
      1:       cp = CP_RSQUOTE;
      2:       cp = CP_LDQUOTE;
      3:       cp = CP_RDQUOTE;
      4:       cp = CP_ENDASH;
      default: cp = CP_EMDASH;
    endcase
    return cp;
  endfunction

  function automatic void gen_string(input int max_parts);
    int parts;
    int pick;
    int n;
    logic [31:0] cp;
    logic [7:0] c;
    start_due = 1'b1;
    n_strings++;
    parts = $urandom_range(0, max_parts);
    repeat (parts) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        do begin
          if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(8'h01, 8'hBF));
          else c = 8'($urandom_range(8'h20, 8'h7E));
        end while (c == CH_QUOTE || c == CH_BACKSLASH);
        feed(c);
      end else if (pick < 50) begin
        feed(CH_BACKSLASH);
        case ($urandom_range(0, 5))
          0:       feed(CH_LOWER_N);
          1:       feed(CH_LOWER_T);
          2:       feed(CH_LOWER_R);
          3:       feed(CH_QUOTE);
          4:       feed(CH_BACKSLASH);
          default: feed(8'($urandom_range(1, 255)));
        endcase
      end else if (pick < 65) begin
        case ($urandom_range(0, 2))
          0:       cp = wide_cp($urandom_range(0, 5));
          1:       cp = $urandom_range(0, 255);
          default: cp = $urandom_range(0, 16'hFFFF);
        endcase
        feed(CH_BACKSLASH);
        feed(CH_LOWER_U);
        for (n = 3; n >= 0; n--) feed(hex_char(cp[n*4 +: 4]));
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: begin
            feed(8'($urandom_range(8'hC0, 8'hDF)));
            feed(cont_byte());
          end
          1: begin
            feed(8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) feed(cont_byte());
          end
          2: begin
            feed(8'($urandom_range(8'hF0, 8'hFF)));
            repeat (3) feed(cont_byte());
          end
          default: begin
            cp = wide_cp($urandom_range(0, 5));
            feed(UTF_LEAD3 | 8'(cp[15:12]));
            feed(UTF_CONT_TAG | 8'(cp[11:6]));
            feed(UTF_CONT_TAG | 8'(cp[5:0]));
          end
        endcase
      end else if (pick < 93) begin
        case ($urandom_range(0, 2))
          0: begin
            // sequence cut short by an ordinary byte
            c = 8'($urandom_range(8'hC0, 8'hFF));
            feed(c);
            if (c >= UTF_LEAD3 && $urandom_range(0, 1)) feed(cont_byte());
            feed(8'($urandom_range(8'h20, 8'h7E)));
          end
          1: begin
            feed(CH_BACKSLASH);
            feed(CH_LOWER_U);
            repeat (4) feed(8'($urandom_range(1, 255)));
          end
          default: begin
            // nul part-way through the hex digits
            feed(CH_BACKSLASH);
            feed(CH_LOWER_U);
            repeat ($urandom_range(0, 3)) feed(hex_char(4'($urandom_range(0, 15))));
            feed(CH_NUL);
          end
        endcase
      end else begin
        feed(8'($urandom_range(0, 255)));
      end
    end
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      feed(CH_QUOTE);
    end else if (pick < 17) begin
      feed(CH_NUL);
    end else if (pick < 18) begin
      feed(CH_BACKSLASH);
      feed(CH_NUL);
    end
    // bytes after the end are dropped by the block
    if (pick < 18 && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) feed(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (n_in != n_fed || decoded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(input logic [MAX_WIDTH-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_bytes <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    n_cfg++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input side driver
  always @(posedge clk) begin : body_driver
    body_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (body_q.size() != 0) begin
        nxt = body_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= nxt.data;
        in_ch.string_start <= nxt.first;
        if (idle_en && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: predicts on each input transfer, checks each result transfer
  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) pr_max = cfg_ch.max_bytes;
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.in_byte, in_ch.string_start);
        n_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_byte: out_ch.out_byte, byte_valid: out_ch.byte_valid,
                string_done: out_ch.string_done, run_last: out_ch.run_last};
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %02h valid %0b done %0b last %0b",
                   $time, got.out_byte, got.byte_valid, got.string_done, got.run_last);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          n_checked++;
          check_field("out_byte", want.out_byte, got.out_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
          check_field("string_done", 8'(want.string_done), 8'(got.string_done));
          check_field("run_last", 8'(want.run_last), 8'(got.run_last));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time, quiet,
             decoded_q.size());
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int goal;
    logic [MAX_WIDTH-1:0] setting;
    logic [MAX_WIDTH-1:0] lo;
    logic [MAX_WIDTH-1:0] hi;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.string_start = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_bytes = MAX_BYTES_RESET;
    idle_en = 1'b1;
    lo = MAX_BYTES_RESET;
    hi = MAX_BYTES_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: escapes, bare continuation, curly quote in utf-8, cut-short sequence,
    // dash via \u, non-hex digit, nul inside \u, empty string, backslash then nul
    start_due = 1'b1;
    feed_text("a\\n\\t\\r\\q");
    feed(UTF_CONT_TAG);
    feed(8'hE2);
    feed(8'h80);
    feed(8'h99);
    feed(8'hC3);
    feed_text("A\\u2014\\ug0");
    feed(CH_NUL);
    start_due = 1'b1;
    feed(CH_QUOTE);
    start_due = 1'b1;
    feed(CH_BACKSLASH);
    feed(CH_NUL);
    n_strings += 3;
    wait_drained();

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       setting = 16'd65535;
        1:       setting = 16'd5;
        2:       setting = 16'($urandom_range(6, 12));
        3:       setting = 16'($urandom_range(13, 40));
        4:       setting = 16'd6;
        5:       setting = 16'($urandom_range(41, 300));
        default: setting = 16'($urandom_range(5, 30));
      endcase
      write_max(setting);
      if (setting < lo) lo = setting;
      if (setting > hi) hi = setting;
      // last phase runs flat out on both sides
      idle_en = (ph != 6);
      goal = n_fed + PHASE_BYTES;
      while (n_fed < goal) gen_string(12);
      wait_drained();
    end

    $display("%0d body bytes over %0d strings, %0d results checked", n_in, n_strings, n_checked);
    $display("%0d max_bytes writes, range %0d to %0d", n_cfg, lo, hi);
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d results never arrived, oldest expected byte %02h", $time,
               decoded_q.size(), decoded_q[0].out_byte);
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/jsu_pkg.sv
src/jsu_if.sv
src/jsu_decode.sv
src/jsu_result_queue.sv
src/json_string_unescape_utf8_top.sv
tb/tb.sv
